// ===== rtl/echo_distance_smoother_assert.svh =====
// Assertion macros for the echo distance smoother.
// Included by modules that check their own logic; relies on clk and arst_n in scope.
`ifndef ECHO_DISTANCE_SMOOTHER_ASSERT_SVH
`define ECHO_DISTANCE_SMOOTHER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset
`define EDS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("echo_distance_smoother assertion failed");
// Next-cycle implication, checked outside reset
`define EDS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("echo_distance_smoother assertion failed");
`else
`define EDS_ASSERT_IMP(lbl, ante, cons)
`define EDS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/edsm_pkg.sv =====
// Shared types and constants for the echo distance smoother.
// No dependencies; used by every module of the block.
package edsm_pkg;

	localparam int TICKS_W = 16;
	localparam int CM_W    = 9;

	// Timer ticks per centimeter of range
	localparam int TICKS_PER_CM = 117;

	// Reset values of the configuration registers
	localparam logic [TICKS_W-1:0] MAX_TICKS_RST     = 16'd35000;
	localparam logic [CM_W-1:0]    MIN_RANGE_CM_RST  = 9'd2;
	localparam logic [CM_W-1:0]    MAX_RANGE_CM_RST  = 9'd400;
	localparam logic [CM_W-1:0]    JUMP_LIMIT_CM_RST = 9'd100;

	// Exact floor(ticks / TICKS_PER_CM) as a multiply by a rounded-up reciprocal
	localparam int TPC_SHIFT  = TICKS_W + $clog2(TICKS_PER_CM);
	localparam int TPC_PROD_W = TPC_SHIFT + TICKS_W;
	localparam logic [TPC_PROD_W-1:0] TPC_RECIP = TPC_PROD_W'(
		((64'd1 << TPC_SHIFT) + 64'(TICKS_PER_CM) - 64'd1) / 64'(TICKS_PER_CM));

	// 70/30 blend weights and their denominator
	localparam int BLEND_NEW = 7;
	localparam int BLEND_OLD = 3;
	localparam int BLEND_DEN = 10;

	// Weighted sum width and its exact reciprocal divide
	localparam int SUM_W      = CM_W + $clog2(BLEND_DEN);
	localparam int DEN_SHIFT  = SUM_W + $clog2(BLEND_DEN);
	localparam int DEN_PROD_W = DEN_SHIFT + SUM_W;
	localparam logic [DEN_PROD_W-1:0] DEN_RECIP = DEN_PROD_W'(
		((64'd1 << DEN_SHIFT) + 64'(BLEND_DEN) - 64'd1) / 64'(BLEND_DEN));

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_MAX_TICKS     = 2'd0,
		REG_MIN_RANGE_CM  = 2'd1,
		REG_MAX_RANGE_CM  = 2'd2,
		REG_JUMP_LIMIT_CM = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [TICKS_W-1:0] max_ticks;
		logic [CM_W-1:0]    min_range_cm;
		logic [CM_W-1:0]    max_range_cm;
		logic [CM_W-1:0]    jump_limit_cm;
	} cfg_t;

endpackage

// ===== rtl/echo_distance_smoother.sv =====
// Echo distance smoother top level: three-stage pipeline, ticks in, centimeters out.
// An accepted input beat passes the input, range and result registers to the master side.
// Throughput: one beat per cycle unless stalled; the divide and the blend each fit one stage.
// Backpressure stalls only the stages behind a full slot, so bubbles fill while stalled.
// Reset: arst_n clears valids, filter state (prev raw, smoothed) and loads default config.
// Depends on edsm_pkg, edsm_cfg, edsm_range and edsm_filter.
module echo_distance_smoother (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [edsm_pkg::TICKS_W-1:0] s_tdata,   // [15:0] pulse_ticks
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [23:0]                  m_tdata,   // [8:0] distance_out, [17:9] raw_cm, zeros above
	output logic                         m_tuser,   // [0] glitch_held
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [1:0]                   cfg_index,
	input  logic [edsm_pkg::TICKS_W-1:0] cfg_data
);

	edsm_pkg::cfg_t               cfg;
	logic                         valid_s1;
	logic [edsm_pkg::TICKS_W-1:0] ticks_s1;
	logic                         ready_s1;
	logic                         valid_s2;
	logic [edsm_pkg::CM_W-1:0]    raw_s2;
	logic                         ready_s2;
	logic [edsm_pkg::CM_W-1:0]    dist_q;
	logic [edsm_pkg::CM_W-1:0]    raw_q;
	logic                         glitch_q;

	edsm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Input register: take a beat whenever stage 1 is free or draining
	assign s_tready = !valid_s1 || ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ticks_s1 <= s_tdata;
		end
	end

	edsm_range u_range (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_s1 (valid_s1),
		.ticks_s1 (ticks_s1),
		.ready_s1 (ready_s1),
		.valid_s2 (valid_s2),
		.raw_s2   (raw_s2),
		.ready_s2 (ready_s2)
	);

	edsm_filter u_filter (
		.clk           (clk),
		.arst_n        (arst_n),
		.jump_limit_cm (cfg.jump_limit_cm),
		.valid_s2      (valid_s2),
		.raw_s2        (raw_s2),
		.ready_s2      (ready_s2),
		.out_valid_q   (m_tvalid),
		.dist_q        (dist_q),
		.raw_q         (raw_q),
		.glitch_q      (glitch_q),
		.out_ready     (m_tready)
	);

	// Pack the result beat
	assign m_tdata = {6'd0, raw_q, dist_q};
	assign m_tuser = glitch_q;

endmodule

// ===== rtl/edsm_cfg.sv =====
// Configuration register file for the echo distance smoother.
// Depends on edsm_pkg for the register indexes and the cfg_t bundle.
module edsm_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [edsm_pkg::TICKS_W-1:0] cfg_data,
	output edsm_pkg::cfg_t              cfg
);

	edsm_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	// Decode the index and load the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_ticks     <= edsm_pkg::MAX_TICKS_RST;
			cfg_q.min_range_cm  <= edsm_pkg::MIN_RANGE_CM_RST;
			cfg_q.max_range_cm  <= edsm_pkg::MAX_RANGE_CM_RST;
			cfg_q.jump_limit_cm <= edsm_pkg::JUMP_LIMIT_CM_RST;
		end else if (cfg_valid) begin
			unique case (edsm_pkg::cfg_idx_t'(cfg_index))
				edsm_pkg::REG_MAX_TICKS:     cfg_q.max_ticks     <= cfg_data;
				edsm_pkg::REG_MIN_RANGE_CM:  cfg_q.min_range_cm  <= cfg_data[edsm_pkg::CM_W-1:0];
				edsm_pkg::REG_MAX_RANGE_CM:  cfg_q.max_range_cm  <= cfg_data[edsm_pkg::CM_W-1:0];
				edsm_pkg::REG_JUMP_LIMIT_CM: cfg_q.jump_limit_cm <= cfg_data[edsm_pkg::CM_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/edsm_range.sv =====
// Range stage: pulse width to raw distance, registered into stage 2.
// Depends on edsm_pkg for the reciprocal constants and cfg_t.
module edsm_range (
	input  logic                         clk,
	input  logic                         arst_n,
	input  edsm_pkg::cfg_t               cfg,
	input  logic                         valid_s1,
	input  logic [edsm_pkg::TICKS_W-1:0] ticks_s1,
	output logic                         ready_s1,
	output logic                         valid_s2,
	output logic [edsm_pkg::CM_W-1:0]    raw_s2,
	input  logic                         ready_s2
);

	logic [edsm_pkg::TPC_PROD_W-1:0] prod;
	logic [edsm_pkg::TICKS_W-1:0]    quot;
	logic                            no_echo;
	logic [edsm_pkg::CM_W-1:0]       raw;

	// Accept from stage 1 when stage 2 is empty or moving on
	assign ready_s1 = !valid_s2 || ready_s2;

	// Divide by ticks per centimeter through the reciprocal
	assign prod = edsm_pkg::TPC_PROD_W'(ticks_s1) * edsm_pkg::TPC_RECIP;
	assign quot = prod[edsm_pkg::TPC_PROD_W-1:edsm_pkg::TPC_SHIFT];

	assign no_echo = (ticks_s1 == '0) || (ticks_s1 > cfg.max_ticks);

	// Zero on no echo, clamp up to the minimum, drop readings past the maximum
	always_comb begin
		if (no_echo) begin
			raw = '0;
		end else if (quot < edsm_pkg::TICKS_W'(cfg.min_range_cm)) begin
			raw = cfg.min_range_cm;
		end else if (quot > edsm_pkg::TICKS_W'(cfg.max_range_cm)) begin
			raw = '0;
		end else begin
			raw = quot[edsm_pkg::CM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && valid_s1) begin
			raw_s2 <= raw;
		end
	end

endmodule

// ===== rtl/edsm_filter.sv =====
// Glitch rejection and 70/30 smoother with the result register.
// Depends on edsm_pkg and the assertion macros in echo_distance_smoother_assert.svh.
`include "echo_distance_smoother_assert.svh"

module edsm_filter (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [edsm_pkg::CM_W-1:0] jump_limit_cm,
	input  logic                      valid_s2,
	input  logic [edsm_pkg::CM_W-1:0] raw_s2,
	output logic                      ready_s2,
	output logic                      out_valid_q,
	output logic [edsm_pkg::CM_W-1:0] dist_q,
	output logic [edsm_pkg::CM_W-1:0] raw_q,
	output logic                      glitch_q,
	input  logic                      out_ready
);

	logic [edsm_pkg::CM_W-1:0]       prev_q;
	logic [edsm_pkg::CM_W-1:0]       smooth_q;
	logic [edsm_pkg::CM_W-1:0]       diff;
	logic                            glitch;
	logic                            load;
	logic [edsm_pkg::SUM_W-1:0]      sum;
	logic [edsm_pkg::DEN_PROD_W-1:0] avg_prod;
	logic [edsm_pkg::CM_W-1:0]       avg;
	logic [edsm_pkg::CM_W-1:0]       smooth_nxt;
	logic [edsm_pkg::CM_W-1:0]       dist_sel;

	assign ready_s2 = !out_valid_q || out_ready;
	assign load     = ready_s2 && valid_s2;

	// Reject a jump between two nonzero readings
	assign diff   = (raw_s2 > prev_q) ? (raw_s2 - prev_q) : (prev_q - raw_s2);
	assign glitch = (prev_q != '0) && (raw_s2 != '0) && (diff > jump_limit_cm);

	// Weighted blend, divided by the denominator through its reciprocal
	assign sum = edsm_pkg::SUM_W'(edsm_pkg::BLEND_NEW) * edsm_pkg::SUM_W'(raw_s2)
	           + edsm_pkg::SUM_W'(edsm_pkg::BLEND_OLD) * edsm_pkg::SUM_W'(smooth_q);
	assign avg_prod = edsm_pkg::DEN_PROD_W'(sum) * edsm_pkg::DEN_RECIP;
	assign avg      = avg_prod[edsm_pkg::DEN_SHIFT +: edsm_pkg::CM_W];

	// Seed on the first valid reading, blend after, hold on zero
	always_comb begin
		if (raw_s2 == '0) begin
			smooth_nxt = smooth_q;
		end else if (smooth_q == '0) begin
			smooth_nxt = raw_s2;
		end else begin
			smooth_nxt = avg;
		end
	end

	// Pick the reported distance
	always_comb begin
		if (glitch) begin
			dist_sel = prev_q;
		end else if (smooth_nxt != '0) begin
			dist_sel = smooth_nxt;
		end else begin
			dist_sel = raw_s2;
		end
	end

	// Advance the output valid when stage 2 may move; filter state only on accepted, non-jump readings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			smooth_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ready_s2) begin
				out_valid_q <= valid_s2;
			end
			if (load && !glitch) begin
				prev_q   <= raw_s2;
				smooth_q <= smooth_nxt;
			end
		end
	end

	// Hold the result beat until taken
	always_ff @(posedge clk) begin
		if (load) begin
			dist_q   <= dist_sel;
			raw_q    <= raw_s2;
			glitch_q <= glitch;
		end
	end

	`EDS_ASSERT_IMP(a_glitch_nonzero, out_valid_q && glitch_q, (raw_q != '0) && (dist_q != '0))
	`EDS_ASSERT_NEXT(a_glitch_keeps_state, load && glitch, $stable(prev_q) && $stable(smooth_q))
	`EDS_ASSERT_NEXT(a_smooth_sticky, smooth_q != '0, smooth_q != '0)
	`EDS_ASSERT_IMP(a_dist_nonzero, out_valid_q && (raw_q != '0), dist_q != '0)

endmodule

// ===== sim/tb_echo_distance_smoother.sv =====
// Self-checking bench for echo_distance_smoother: pulse widths in, distance beats out.
// Predicts each result beat with its own range/jump/smoothing tracker, field by field.
// Depends on edsm_pkg and the echo_distance_smoother RTL.
`timescale 1ns / 100ps

module tb_echo_distance_smoother;

	typedef struct packed {
		logic [edsm_pkg::CM_W-1:0] dist_cm;
		logic [edsm_pkg::CM_W-1:0] raw;
		logic                      glitch;
	} reading_t;

	// Tracks config, filter state and the readings still owed by the block
	class range_ledger;
		logic [edsm_pkg::TICKS_W-1:0] max_ticks;
		logic [edsm_pkg::CM_W-1:0]    min_cm;
		logic [edsm_pkg::CM_W-1:0]    max_cm;
		logic [edsm_pkg::CM_W-1:0]    jump_cm;
		logic [edsm_pkg::CM_W-1:0]    last_raw;
		logic [edsm_pkg::CM_W-1:0]    avg_cm;
		reading_t                     owed[$];
		int                           pulses;
		int                           beats;
		int                           glitches;
		int                           mismatches;

		function new();
			max_ticks  = edsm_pkg::MAX_TICKS_RST;
			min_cm     = edsm_pkg::MIN_RANGE_CM_RST;
			max_cm     = edsm_pkg::MAX_RANGE_CM_RST;
			jump_cm    = edsm_pkg::JUMP_LIMIT_CM_RST;
			last_raw   = '0;
			avg_cm     = '0;
			pulses     = 0;
			beats      = 0;
			glitches   = 0;
			mismatches = 0;
		endfunction

		function void set_reg(edsm_pkg::cfg_idx_t idx, logic [edsm_pkg::TICKS_W-1:0] data);
			case (idx)
				edsm_pkg::REG_MAX_TICKS:     max_ticks = data;
				edsm_pkg::REG_MIN_RANGE_CM:  min_cm    = data[edsm_pkg::CM_W-1:0];
				edsm_pkg::REG_MAX_RANGE_CM:  max_cm    = data[edsm_pkg::CM_W-1:0];
				edsm_pkg::REG_JUMP_LIMIT_CM: jump_cm   = data[edsm_pkg::CM_W-1:0];
				default: ;
			endcase
		endfunction

		// Work out the reading that one accepted pulse produces
		function void take_pulse(logic [edsm_pkg::TICKS_W-1:0] ticks);
			int       q;
			int       delta;
			reading_t r;
			pulses++;
			r.glitch = 1'b0;
			if (ticks == 0 || ticks > max_ticks) begin
				q = 0;
			end else begin
				q = int'(ticks / edsm_pkg::TICKS_PER_CM);
				// clamp up without checking the maximum, then drop out-of-range
				if (q < int'(min_cm)) q = int'(min_cm);
				else if (q > int'(max_cm)) q = 0;
			end
			r.raw = edsm_pkg::CM_W'(q);
			delta = (int'(r.raw) > int'(last_raw)) ? int'(r.raw) - int'(last_raw)
			                                       : int'(last_raw) - int'(r.raw);
			if (last_raw != 0 && r.raw != 0 && delta > int'(jump_cm)) begin
				// jump rejected: hold the previous raw value, leave state alone
				r.dist_cm = last_raw;
				r.glitch  = 1'b1;
				glitches++;
			end else begin
				if (r.raw != 0)
					avg_cm = (avg_cm == 0) ? r.raw
					       : edsm_pkg::CM_W'((7 * int'(r.raw) + 3 * int'(avg_cm)) / 10);
				last_raw  = r.raw;
				r.dist_cm = (avg_cm != 0) ? avg_cm : r.raw;
			end
			owed.push_back(r);
		endfunction

		// Compare one result beat with the oldest owed reading
		function void match_reading(logic [edsm_pkg::CM_W-1:0] dist_cm,
		                            logic [edsm_pkg::CM_W-1:0] raw, logic glitch);
			reading_t w;
			beats++;
			if (owed.size() == 0) begin
				$error("result beat with no reading owed: distance_out %0d raw_cm %0d glitch_held %0b",
				       dist_cm, raw, glitch);
				mismatches++;
				return;
			end
			w = owed.pop_front();
			if (dist_cm !== w.dist_cm) begin
				$error("distance_out: expected %0d, got %0d", w.dist_cm, dist_cm);
				mismatches++;
			end
			if (raw !== w.raw) begin
				$error("raw_cm: expected %0d, got %0d", w.raw, raw);
				mismatches++;
			end
			if (glitch !== w.glitch) begin
				$error("glitch_held: expected %0b, got %0b", w.glitch, glitch);
				mismatches++;
			end
		endfunction
	endclass

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         s_tvalid;
	logic                         s_tready;
	logic [edsm_pkg::TICKS_W-1:0] s_tdata;
	logic                         m_tvalid;
	logic                         m_tready;
	logic [23:0]                  m_tdata;
	logic                         m_tuser;
	logic                         cfg_valid;
	logic                         cfg_ready;
	edsm_pkg::cfg_idx_t           cfg_index;
	logic [edsm_pkg::TICKS_W-1:0] cfg_data;

	range_ledger ledger = new();
	bit          calm;
	int          walk_cm;
	int          settings_used;

	echo_distance_smoother i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Mostly no gap, some short, a few long; none while calm
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	// Pulse widths: mostly a wandering target, some jumps near the limit, some noise
	function automatic logic [edsm_pkg::TICKS_W-1:0] pick_ticks();
		int r;
		int d;
		int step;
		int t;
		r = $urandom_range(0, 99);
		if (r >= 88) return edsm_pkg::TICKS_W'($urandom);
		if (r >= 80)
			return ($urandom_range(0, 1) == 1) ? '0
			       : edsm_pkg::TICKS_W'($urandom_range(int'(ledger.max_ticks), 65535));
		if (r >= 70) begin
			d = int'($urandom_range(0, 560));
		end else begin
			step = (r >= 55) ? int'(ledger.jump_cm) + 2 : 12;
			d = walk_cm + int'($urandom_range(0, 2 * step)) - step;
			if (d < 0) d = 0;
			if (d > 560) d = 560;
		end
		walk_cm = d;
		t = d * edsm_pkg::TICKS_PER_CM + int'($urandom_range(0, edsm_pkg::TICKS_PER_CM - 1));
		return (t > 65535) ? 16'hFFFF : edsm_pkg::TICKS_W'(t);
	endfunction

	// Send one pulse beat; entered and left at a falling edge
	task automatic push_pulse(input logic [edsm_pkg::TICKS_W-1:0] ticks);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = ticks;
		do @(posedge clk); while (!s_tready);
		ledger.take_pulse(ticks);
		@(negedge clk);
	endtask

	// Hold the sender until every owed reading is back, then let the pipe empty
	task automatic settle();
		s_tvalid = 1'b0;
		while (ledger.owed.size() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic poke_reg(input edsm_pkg::cfg_idx_t idx,
	                        input logic [edsm_pkg::TICKS_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		ledger.set_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Load all four registers; spare high bits of the 9-bit ones carry noise
	task automatic load_regs(input logic [edsm_pkg::TICKS_W-1:0] mt,
	                         input logic [edsm_pkg::CM_W-1:0] mn,
	                         input logic [edsm_pkg::CM_W-1:0] mx,
	                         input logic [edsm_pkg::CM_W-1:0] jl);
		poke_reg(edsm_pkg::REG_MAX_TICKS, mt);
		poke_reg(edsm_pkg::REG_MIN_RANGE_CM, {7'($urandom), mn});
		poke_reg(edsm_pkg::REG_MAX_RANGE_CM, {7'($urandom), mx});
		poke_reg(edsm_pkg::REG_JUMP_LIMIT_CM, {7'($urandom), jl});
		settings_used++;
	endtask

	// Random pulses with one full drain halfway through
	task automatic run_readings(input int count);
		for (int n = 0; n < count; n++) begin
			if (n == count / 2) settle();
			push_pulse(pick_ticks());
		end
	endtask

	// Result side: random stalls, check every accepted beat
	initial begin : result_side
		int hold;
		m_tready = 1'b0;
		hold     = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				m_tready = 1'b0;
				hold--;
			end else begin
				m_tready = 1'b1;
				hold     = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			ledger.match_reading(m_tdata[8:0], m_tdata[17:9], m_tuser);
	end

	initial begin : stimulus
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		cfg_valid     = 1'b0;
		cfg_index     = edsm_pkg::REG_MAX_TICKS;
		cfg_data      = '0;
		calm          = 1'b0;
		walk_cm       = 100;
		settings_used = 1;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset settings: no echo, clamp to minimum, jumps just inside and outside the limit
		push_pulse(16'd0);
		push_pulse(16'd65535);
		push_pulse(16'd35001);
		push_pulse(16'd1);
		push_pulse(16'd116);
		push_pulse(16'd117);
		push_pulse(16'd35000);
		push_pulse(16'd351);
		push_pulse(16'd11934);
		push_pulse(16'd23751);
		push_pulse(16'd23750);
		push_pulse(16'd0);
		push_pulse(16'd35000);
		run_readings(100);
		settle();

		// Widest window, back to back: top quotient, zero minimum
		calm = 1'b1;
		load_regs(16'hFFFF, 9'd0, 9'd511, 9'd511);
		push_pulse(16'd65535);
		push_pulse(16'd59787);
		push_pulse(16'd116);
		run_readings(100);
		settle();
		calm = 1'b0;

		// Minimum above maximum: each echo reads as the minimum or is dropped, so the zero jump limit rejects nothing
		load_regs(16'hFFFF, 9'd300, 9'd100, 9'd0);
		push_pulse(16'd5850);
		push_pulse(16'd23400);
		push_pulse(16'd40950);
		run_readings(100);
		settle();

		// Nothing counts as an echo
		load_regs(16'd0, 9'd511, 9'd0, 9'd0);
		push_pulse(16'd1);
		push_pulse(16'd65535);
		run_readings(30);
		settle();

		// Plausible random window
		load_regs(edsm_pkg::TICKS_W'($urandom_range(20000, 65535)),
		          edsm_pkg::CM_W'($urandom_range(0, 20)),
		          edsm_pkg::CM_W'($urandom_range(100, 511)),
		          edsm_pkg::CM_W'($urandom_range(0, 150)));
		run_readings(110);
		settle();

		// Arbitrary register values
		calm = 1'b1;
		load_regs(edsm_pkg::TICKS_W'($urandom), edsm_pkg::CM_W'($urandom),
		          edsm_pkg::CM_W'($urandom), edsm_pkg::CM_W'($urandom));
		run_readings(110);
		settle();
		calm = 1'b0;

		// Reset values restored through the register port
		load_regs(edsm_pkg::MAX_TICKS_RST, edsm_pkg::MIN_RANGE_CM_RST,
		          edsm_pkg::MAX_RANGE_CM_RST, edsm_pkg::JUMP_LIMIT_CM_RST);
		run_readings(90);
		settle();

		$display("Sent %0d pulses under %0d register settings; %0d result beats, %0d jump rejects.",
		         ledger.pulses, settings_used, ledger.beats, ledger.glitches);
		if (ledger.mismatches == 0 && ledger.owed.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Stop a hung run
	initial begin : watchdog
		#5000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
